FILE: hdl/ihg_pkg.sv
// ----------------------------------------------------------------------------
// ihg_pkg
// shared types, name table and helpers for the identity header guard
// ----------------------------------------------------------------------------
package ihg_pkg;

  localparam int NumNames = 6;
  localparam int PosW     = 5;
  localparam int NameIdxW = 3;

  // scan phase of the current request
  typedef enum logic [2:0] {
    PH_LINE_START = 3'd0,
    PH_CR_SEEN    = 3'd1,
    PH_NAME       = 3'd2,
    PH_BLANKS     = 3'd3,
    PH_SKIP       = 3'd4,
    PH_DONE       = 3'd5
  } ihg_phase_e;

  typedef logic [NumNames-1:0] ihg_alive_t;

  localparam ihg_alive_t AllAlive   = '1;
  // caller-subject name, exempt by configuration
  localparam ihg_alive_t ExemptMask = ihg_alive_t'(1) << (NumNames - 1);

  // common eight byte prefix of all names, first char in the top byte
  localparam logic [63:0] NamePrefix = 64'h782d_6169_6d65_652d;
  localparam int PrefixLen = 8;

  // name tails, right justified: last char in the lowest byte
  localparam logic [127:0] NameSuffix [NumNames] = '{
    128'("principal"),
    128'("actor"),
    128'("source"),
    128'("session-key"),
    128'("user"),
    128'("caller-subject")
  };

  localparam logic [PosW-1:0] NameLen [NumNames] = '{
    5'd17, 5'd13, 5'd14, 5'd19, 5'd12, 5'd22
  };

  // char of name k at position pos, meaningful only for pos below its length
  function automatic logic [7:0] name_byte(input logic [NameIdxW-1:0] k,
                                           input logic [PosW-1:0] pos);
    logic [PosW-1:0] rel;
    logic [3:0]      idx;
    logic [127:0]    tail;
    logic [2:0]      pidx;
    begin
      tail = NameSuffix[k];
      rel  = NameLen[k] - 5'd1 - pos;
      idx  = rel[3:0];
      pidx = 3'd7 - pos[2:0];
      if (pos < 5'(PrefixLen)) begin
        name_byte = NamePrefix[{pidx, 3'b000} +: 8];
      end else begin
        name_byte = tail[{idx, 3'b000} +: 8];
      end
    end
  endfunction

  // ascii upper to lower case, other bytes unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    begin
      if (c >= 8'h41 && c <= 8'h5a) begin
        fold_case = c + 8'd32;
      end else begin
        fold_case = c;
      end
    end
  endfunction

endpackage

FILE: hdl/identity_header_guard_unit.sv
// ----------------------------------------------------------------------------
// identity_header_guard_unit
// byte-serial scanner flagging identity header names in a request header block
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload                           | request ends
//  ----------+-----------+-----------------------------------+--------------
//  s_axis    | in        | tdata[7:0] request byte           | tlast = last
//  m_axis    | out       | tdata[0] found flag, rest zero    | one per request
//  cfg       | in        | cfg_data_i exempt caller-subject  | -
//
//  one request byte per cycle while not stalled; each byte updates the scan
//  state in the cycle it is accepted, all six name compares run side by side
//  a request's result is registered, valid in the cycle after its last byte
//  s_axis stalls only while a result sits in the output register and
//  m_axis_tready is low
//  reset clears the scan state and the exempt bit, no clearing pass
//
module identity_header_guard_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request byte stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] request_byte
  input  logic       s_axis_tlast,   // end_of_request
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] identity_header_found, [7:1] zero
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i      // allow_caller_subject
);

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharColon = 8'h3a;

  // scan state
  ihg_pkg::ihg_phase_e            phase_q, phase_d;
  logic [ihg_pkg::PosW-1:0]       pos_q, pos_d;
  ihg_pkg::ihg_alive_t            alive_q, alive_d;
  logic                           found_q, found_d;
  logic                           allow_q;

  // result register
  logic                           out_valid_q, out_valid_d;
  logic                           out_found_q, out_found_d;

  logic                           in_fire;
  logic [7:0]                     in_byte;
  logic [7:0]                     low_byte;
  ihg_pkg::ihg_alive_t            alive_eff;
  ihg_pkg::ihg_alive_t            alive_init;

  // name compare inputs and outputs
  logic [ihg_pkg::PosW-1:0]       cmp_pos;
  ihg_pkg::ihg_alive_t            cmp_alive;
  ihg_pkg::ihg_alive_t            cmp_hit;
  logic                           cmp_complete;
  ihg_pkg::ihg_phase_e            cmp_phase;

  assign in_byte       = s_axis_tdata;
  assign low_byte      = ihg_pkg::fold_case(in_byte);
  // output register frees up when the downstream takes the result
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign alive_eff  = allow_q ? (alive_q & ~ihg_pkg::ExemptMask) : alive_q;
  assign alive_init = allow_q ? (ihg_pkg::AllAlive & ~ihg_pkg::ExemptMask)
                              : ihg_pkg::AllAlive;

  // a fresh line restarts the compare at position zero
  assign cmp_pos   = (phase_q == ihg_pkg::PH_LINE_START) ? '0 : pos_q;
  assign cmp_alive = (phase_q == ihg_pkg::PH_LINE_START) ? alive_init : alive_eff;

  // six parallel compares of this byte against the name table
  always_comb begin
    cmp_hit      = '0;
    cmp_complete = 1'b0;
    for (int k = 0; k < ihg_pkg::NumNames; k++) begin
      if (cmp_alive[k] && (cmp_pos < ihg_pkg::NameLen[k]) &&
          (ihg_pkg::name_byte(ihg_pkg::NameIdxW'(k), cmp_pos) == low_byte)) begin
        cmp_hit[k] = 1'b1;
        if ((cmp_pos + 5'd1) == ihg_pkg::NameLen[k]) begin
          cmp_complete = 1'b1;
        end
      end
    end
    priority if (cmp_complete) begin
      cmp_phase = ihg_pkg::PH_BLANKS;
    end else if (cmp_hit == '0) begin
      cmp_phase = (in_byte == CharLf) ? ihg_pkg::PH_LINE_START : ihg_pkg::PH_SKIP;
    end else begin
      cmp_phase = ihg_pkg::PH_NAME;
    end
  end

  // per-byte scan step
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    alive_d = alive_q;
    found_d = found_q;
    if (in_fire) begin
      // the exempt mask sticks to the candidate set once applied
      alive_d = alive_eff;
      if (in_byte == CharNul && phase_q != ihg_pkg::PH_DONE) begin
        phase_d = ihg_pkg::PH_DONE;
      end else begin
        unique case (phase_q)
          ihg_pkg::PH_LINE_START: begin
            if (in_byte == CharLf) begin
              phase_d = ihg_pkg::PH_DONE;   // blank line ends the headers
            end else if (in_byte == CharCr) begin
              phase_d = ihg_pkg::PH_CR_SEEN;
            end else begin
              phase_d = cmp_phase;
              pos_d   = cmp_pos + 5'd1;
              alive_d = cmp_hit;
            end
          end
          ihg_pkg::PH_CR_SEEN: begin
            phase_d = (in_byte == CharLf) ? ihg_pkg::PH_DONE : ihg_pkg::PH_SKIP;
          end
          ihg_pkg::PH_NAME: begin
            phase_d = cmp_phase;
            pos_d   = cmp_pos + 5'd1;
            alive_d = cmp_hit;
          end
          ihg_pkg::PH_BLANKS: begin
            priority if (alive_eff == '0) begin
              phase_d = (in_byte == CharLf) ? ihg_pkg::PH_LINE_START
                                            : ihg_pkg::PH_SKIP;
            end else if (in_byte == CharColon) begin
              found_d = 1'b1;
              phase_d = ihg_pkg::PH_DONE;
            end else if (in_byte == CharSpace || in_byte == CharTab) begin
              phase_d = ihg_pkg::PH_BLANKS;
            end else if (in_byte == CharLf) begin
              phase_d = ihg_pkg::PH_LINE_START;
            end else begin
              phase_d = ihg_pkg::PH_SKIP;
            end
          end
          ihg_pkg::PH_SKIP: begin
            if (in_byte == CharLf) begin
              phase_d = ihg_pkg::PH_LINE_START;
            end
          end
          default: begin
            phase_d = ihg_pkg::PH_DONE;     // done, or a meaningless code
          end
        endcase
      end
    end
  end

  // result register: load on the last byte, drain on the downstream handshake
  always_comb begin
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && s_axis_tlast) begin
      out_valid_d = 1'b1;
      out_found_d = found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ihg_pkg::PH_LINE_START;
      pos_q       <= '0;
      alive_q     <= ihg_pkg::AllAlive;
      found_q     <= 1'b0;
      allow_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire && s_axis_tlast) begin
        // next request starts from a clean scan
        phase_q <= ihg_pkg::PH_LINE_START;
        pos_q   <= '0;
        alive_q <= ihg_pkg::AllAlive;
        found_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        alive_q <= alive_d;
        found_q <= found_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        allow_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_found_q};

`ifndef NO_ASSERTIONS
  // a match always stops the scan
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (phase_q == ihg_pkg::PH_DONE))
    else $error("found flag set outside done phase");

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_valid_q)
    else $error("input stalled with empty result register");

  // the last byte of a request clears the scan and yields a result
  a_request_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> (phase_q == ihg_pkg::PH_LINE_START &&
                                   pos_q == '0 && !found_q && out_valid_q))
    else $error("scan not cleared after end of request");

  // mid-name there is a live candidate and some progress
  a_name_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ihg_pkg::PH_NAME) |-> (alive_q != '0 && pos_q != '0))
    else $error("name phase without live candidate");
`endif

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for identity_header_guard_unit: byte streams of header
// blocks with listed names in random case, near misses, blank lines, bare CR
// lines, zero bytes and cut-off messages go in on s_axis; a scan model in the
// bench predicts the found flag of each message and the flags coming out on
// m_axis are compared in order, under random stalls on both sides
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int ErrPrintMax = 40;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3a;

  // one byte request on s_axis
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] request_byte
  logic       s_axis_tlast  = 1'b0;    // end_of_request
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [0] identity_header_found, [7:1] zero
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i    = 1'b0;    // allow_caller_subject

  // scan model state
  ihg_pkg::ihg_phase_e      scan_ph;
  logic [ihg_pkg::PosW-1:0] name_pos;
  ihg_pkg::ihg_alive_t      alive_set;
  logic                     found_bit;
  logic                     exempt_cs;
  string                    hdr_name [ihg_pkg::NumNames];

  // expected found flags, oldest first
  logic        found_q [$];
  // message under construction and byte requests waiting for the driver
  logic [7:0]  msg_buf [$];
  byte_req_t   byte_req_q [$];
  int          bytes_queued = 0;
  int          msgs_queued  = 0;

  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          err_count    = 0;
  int unsigned cycle_cnt    = 0;

  identity_header_guard_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- scan model

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  task automatic clear_scan();
    scan_ph   = ihg_pkg::PH_LINE_START;
    name_pos  = '0;
    alive_set = ihg_pkg::AllAlive;
    found_bit = 1'b0;
  endtask

  // one byte against all names still in the race
  task automatic match_names(input logic [7:0] c);
    logic [7:0]          lc;
    ihg_pkg::ihg_alive_t nxt;
    logic                hit_end;
    int                  k;
    lc      = to_lower(c);
    nxt     = '0;
    hit_end = 1'b0;
    for (k = 0; k < ihg_pkg::NumNames; k++) begin
      if (alive_set[k] && name_pos < hdr_name[k].len() &&
          hdr_name[k].getc(name_pos) == lc) begin
        nxt[k] = 1'b1;
        if (name_pos + 1 == hdr_name[k].len()) hit_end = 1'b1;
      end
    end
    alive_set = nxt;
    name_pos  = name_pos + 1'b1;
    if (hit_end) scan_ph = ihg_pkg::PH_BLANKS;
    else if (nxt == '0) scan_ph = (c == ChLf) ? ihg_pkg::PH_LINE_START : ihg_pkg::PH_SKIP;
    else scan_ph = ihg_pkg::PH_NAME;
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic last);
    if (exempt_cs) alive_set = alive_set & ~ihg_pkg::ExemptMask;
    // a zero byte ends the scan like a string terminator
    if (c == ChNul && scan_ph != ihg_pkg::PH_DONE) begin
      scan_ph = ihg_pkg::PH_DONE;
    end else begin
      case (scan_ph)
        ihg_pkg::PH_LINE_START: begin
          if (c == ChLf) begin
            scan_ph = ihg_pkg::PH_DONE;
          end else if (c == ChCr) begin
            scan_ph = ihg_pkg::PH_CR_SEEN;
          end else begin
            name_pos  = '0;
            alive_set = exempt_cs ? (ihg_pkg::AllAlive & ~ihg_pkg::ExemptMask)
                                  : ihg_pkg::AllAlive;
            match_names(c);
          end
        end
        ihg_pkg::PH_CR_SEEN: begin
          scan_ph = (c == ChLf) ? ihg_pkg::PH_DONE : ihg_pkg::PH_SKIP;
        end
        ihg_pkg::PH_NAME: match_names(c);
        ihg_pkg::PH_BLANKS: begin
          if (alive_set == '0) begin
            scan_ph = (c == ChLf) ? ihg_pkg::PH_LINE_START : ihg_pkg::PH_SKIP;
          end else if (c == ChColon) begin
            found_bit = 1'b1;
            scan_ph   = ihg_pkg::PH_DONE;
          end else if (c == ChSpace || c == ChTab) begin
            scan_ph = ihg_pkg::PH_BLANKS;
          end else if (c == ChLf) begin
            scan_ph = ihg_pkg::PH_LINE_START;
          end else begin
            scan_ph = ihg_pkg::PH_SKIP;
          end
        end
        ihg_pkg::PH_SKIP: begin
          if (c == ChLf) scan_ph = ihg_pkg::PH_LINE_START;
        end
        default: scan_ph = ihg_pkg::PH_DONE;
      endcase
    end
    if (last) begin
      found_q.push_back(found_bit);
      clear_scan();
    end
  endtask

  // ------------------------------------------------------------ driver/monitor

  // byte requests: hold while stalled, otherwise maybe idle, else next byte
  always @(posedge clk_i or negedge rst_ni) begin : byte_drv
    byte_req_t nb;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nb = byte_req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nb.data;
          s_axis_tlast  <= nb.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what);
    if (err_count < ErrPrintMax) $display("%0t mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // result requests: compare against the oldest expected flag, pad bits must be zero
  always @(posedge clk_i or negedge rst_ni) begin : result_mon
    logic want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (found_q.size() == 0) begin
          report_mismatch("result with no message outstanding");
        end else begin
          want = found_q.pop_front();
          if (m_axis_tdata[0] !== want)
            report_mismatch($sformatf("found flag %b, expected %b", m_axis_tdata[0], want));
          if (m_axis_tdata[7:1] !== 7'd0)
            report_mismatch($sformatf("pad bits %b not zero", m_axis_tdata[7:1]));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------- message builders

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) msg_buf.push_back(s.getc(i));
  endtask

  task automatic add_text(input int n);
    repeat (n) msg_buf.push_back(8'($urandom_range(32, 126)));
  endtask

  task automatic add_eol();
    if ($urandom_range(1)) msg_buf.push_back(ChCr);
    msg_buf.push_back(ChLf);
  endtask

  // case_mode: 0 lower, 1 upper, 2 random per letter
  task automatic add_name(input int k, input int case_mode);
    logic [7:0] c;
    int         i;
    for (i = 0; i < hdr_name[k].len(); i++) begin
      c = hdr_name[k].getc(i);
      if (c >= 8'h61 && c <= 8'h7a &&
          (case_mode == 1 || (case_mode == 2 && $urandom_range(1))))
        c = c - 8'd32;
      msg_buf.push_back(c);
    end
  endtask

  task automatic queue_message();
    byte_req_t b;
    int        i;
    if (msg_buf.size() == 0) msg_buf.push_back(8'($urandom_range(255)));
    for (i = 0; i < msg_buf.size(); i++) begin
      b.data = msg_buf[i];
      b.last = (i == msg_buf.size() - 1);
      byte_req_q.push_back(b);
    end
    bytes_queued += msg_buf.size();
    msgs_queued++;
    msg_buf.delete();
  endtask

  // wait until every byte is in and every flag is out, then let it settle
  task automatic settle();
    do @(negedge clk_i);
    while (byte_req_q.size() != 0 || s_axis_tvalid || found_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_exempt(input logic v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    exempt_cs = v;
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well formed header blocks with random content, some raw noise
  task automatic random_chunk(input int src_pct, input int snk_pct, input logic exempt);
    int n0, m0, r, k, cut, pos;
    settle();
    write_exempt(exempt);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    n0 = bytes_queued + 50;
    m0 = msgs_queued + 2;
    while (bytes_queued < n0 || msgs_queued < m0) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 12)) msg_buf.push_back(8'($urandom_range(255)));
      end else begin
        // optional request line
        if ($urandom_range(1)) begin
          add_text($urandom_range(1, 10));
          add_eol();
        end
        repeat ($urandom_range(0, 3)) begin
          r = $urandom_range(99);
          k = $urandom_range(ihg_pkg::NumNames - 1);
          if (r < 45) begin
            // listed name, blanks, mostly a colon
            add_name(k, 2);
            repeat ($urandom_range(0, 2)) msg_buf.push_back($urandom_range(1) ? ChSpace : ChTab);
            msg_buf.push_back($urandom_range(99) < 85 ? ChColon : 8'($urandom_range(33, 126)));
            add_text($urandom_range(0, 4));
          end else if (r < 60) begin
            // near miss: cut short or one byte changed
            add_name(k, 2);
            if ($urandom_range(1)) begin
              cut = $urandom_range(1, hdr_name[k].len() - 1);
              repeat (cut) void'(msg_buf.pop_back());
            end else begin
              pos = msg_buf.size() - 1 - $urandom_range(hdr_name[k].len() - 1);
              msg_buf[pos] = 8'($urandom_range(255));
            end
            msg_buf.push_back(ChColon);
          end else if (r < 70) begin
            // bare cr at line start
            msg_buf.push_back(ChCr);
            add_text($urandom_range(1, 3));
          end else begin
            add_text($urandom_range(1, 8));
          end
          add_eol();
        end
        // how the message ends
        r = $urandom_range(99);
        if (r < 60) begin
          add_eol();
          repeat ($urandom_range(0, 4)) msg_buf.push_back(8'($urandom_range(255)));
        end else if (r < 75) begin
          msg_buf.push_back(ChNul);
          repeat ($urandom_range(0, 3)) msg_buf.push_back(8'($urandom_range(255)));
        end else if (r >= 90) begin
          cut = $urandom_range(msg_buf.size() / 2);
          repeat (cut) void'(msg_buf.pop_back());
        end
      end
      queue_message();
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    string pre;
    pre = "x-ai";
    pre = {pre, "mee-"};
    hdr_name[0] = {pre, "principal"};
    hdr_name[1] = {pre, "actor"};
    hdr_name[2] = {pre, "source"};
    hdr_name[3] = {pre, "session-key"};
    hdr_name[4] = {pre, "user"};
    hdr_name[5] = {pre, "caller-subject"};
    exempt_cs = 1'b0;
    clear_scan();
    src_idle_pct = 36;
    snk_idle_pct = 48;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_exempt(1'b0);

    // upper case name, crlf blank line
    add_name(0, 1); add_str(":a\r\n\r\n"); queue_message();
    // mixed blanks before the colon
    add_name(1, 0); add_str(" \t :\n\n"); queue_message();
    // request line first, then a match
    add_str("GET / HTTP/1.1\r\n"); add_name(2, 2); add_str(":x\r\n\r\n"); queue_message();
    // blank line ends the block before the name
    add_str("\r\n"); add_name(3, 0); add_str(":\r\n"); queue_message();
    add_str("\n"); add_name(4, 0); add_str(":"); queue_message();
    // cr not followed by lf skips that line
    add_str("\r"); add_name(4, 0); add_str(":\n\r\n"); queue_message();
    add_str("\rq\n"); add_name(4, 1); add_str(":"); queue_message();
    // zero byte stops the scan
    add_str("a\n"); msg_buf.push_back(ChNul); add_name(0, 0); add_str(":"); queue_message();
    // caller-subject counts while not exempt
    add_name(5, 0); add_str(":\n"); queue_message();
    // message ends in the middle of a name
    add_name(2, 0); repeat (3) void'(msg_buf.pop_back()); queue_message();
    // extra char after a full name
    add_name(2, 0); add_str("x:\n\n"); queue_message();
    // junk after blanks skips the line, next line matches
    add_name(1, 0); add_str(" x:\n"); add_name(3, 1); add_str("\t:"); queue_message();
    // proper prefix of a longer name
    add_name(3, 0); repeat (4) void'(msg_buf.pop_back()); add_str(":\n\n"); queue_message();
    // bytes after a match are ignored
    add_name(0, 0); add_str(":");
    msg_buf.push_back(8'hff); msg_buf.push_back(ChNul); msg_buf.push_back(8'h80);
    add_str("\r\n\r\n"); queue_message();
    // one byte messages
    msg_buf.push_back(8'hff); queue_message();
    msg_buf.push_back(ChNul); queue_message();
    // only a..z fold: cr in place of the dash, high byte in place of a letter
    add_name(1, 0); msg_buf[1] = ChCr; add_str(":\n"); queue_message();
    add_name(4, 0); msg_buf[msg_buf.size() - 1] = 8'hf2; add_str(":"); queue_message();
    // name line without colon, then a match
    add_name(4, 0); add_str("\n"); add_name(0, 0); add_str(" :"); queue_message();

    settle();
    write_exempt(1'b1);
    // exempt name no longer counts, others still do
    add_name(5, 1); add_str(":\r\n\r\n"); queue_message();
    add_name(5, 0); add_str(":\n"); add_name(0, 2); add_str(":\n\n"); queue_message();

    random_chunk(36, 48, 1'b0);
    random_chunk(36, 48, 1'b1);
    random_chunk(48, 36, 1'b0);
    random_chunk(48, 36, 1'b1);
    random_chunk(0, 0, 1'b1);
    random_chunk(0, 0, 1'b0);

    settle();
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && found_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: identity_header_guard_unit.f
hdl/ihg_pkg.sv
hdl/identity_header_guard_unit.sv
tb/sv/tb.sv
